FILE: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the stable priority queue
// Entry layout, command and status codes, and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PRIO_W      = 8;
  localparam int DATA_W      = 32;
  localparam int OCC_W       = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] payload;
  } entry_t;

  // Per-cycle control broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;  // insert the new entry into its sorted place
    logic del;  // pop the head, every cell takes its right neighbour
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted entry chain
// Holds one entry; on insert keeps, takes the new entry or takes its left
// neighbour; on delete takes its right neighbour.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire                       clk_i,
  input  wire spq_pkg::cell_ctl_t   ctl_i,
  input  wire                       valid_i,
  input  wire spq_pkg::entry_t      new_entry_i,
  input  wire spq_pkg::entry_t      left_entry_i,
  input  wire                       left_ge_i,
  input  wire spq_pkg::entry_t      right_entry_i,
  output spq_pkg::entry_t           entry_o,
  output logic                      ge_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // Entries stay sorted by descending priority, ties in arrival order, so a
  // new entry settles behind every held entry of equal or higher priority.
  assign ge_o = valid_i && (entry_q.prio >= new_entry_i.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.del) begin
      entry_d = right_entry_i;
    end else if (ctl_i.ins && !ge_o) begin
      entry_d = left_ge_i ? new_entry_i : left_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded priority queue with FIFO order among equals
// A chain of cells keeps the entries sorted; head is always the next to leave.
// ----------------------------------------------------------------------------
// A command beat is taken when start is high and busy is low. The chain
// updates in the cycle of acceptance and the result is shown on the next
// cycle with done_o high for exactly that one cycle; the receiver cannot
// stall it, so capture it then. busy is high during that result cycle, so
// a new command is taken only once the result strobe is over. Every cell
// compares the new priority with its own in parallel, so the time a command
// takes does not grow with the queue depth. An insert on a full queue is
// dropped and reports full; a delete on an empty queue reports empty.
// Priority and data outputs are zero unless an entry was removed; occupancy
// always gives the count held after the command.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  output logic                        busy,
  input  wire                         cmd_i,
  input  wire  [spq_pkg::PRIO_W-1:0]  prio_in_i,
  input  wire  [spq_pkg::DATA_W-1:0]  payload_in_i,
  output logic                        done_o,
  output logic [spq_pkg::PRIO_W-1:0]  prio_out_o,
  output logic [spq_pkg::DATA_W-1:0]  payload_out_o,
  output logic [1:0]                  status_o,
  output logic [spq_pkg::OCC_W-1:0]   occupancy_o
);
  import spq_pkg::*;

  logic                 accept;
  logic                 is_del;
  logic                 full;
  logic                 empty;
  logic [CNT_W-1:0]     count_q, count_d;
  logic                 busy_q;
  logic [PRIO_W-1:0]    prio_out_q, prio_out_d;
  logic [DATA_W-1:0]    payload_out_q, payload_out_d;
  status_e              status_q, status_d;
  cell_ctl_t            ctl;
  entry_t               new_entry;
  entry_t               cell_entry [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_ge;
  logic [QUEUE_DEPTH-1:0] cell_valid;

  assign accept = start && !busy_q;
  assign is_del = (cmd_e'(cmd_i) == CMD_DELETE);
  assign full   = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  assign new_entry.prio    = prio_in_i;
  assign new_entry.payload = payload_in_i;

  // Drive the chain only for commands that change the state.
  assign ctl.ins = accept && !is_del && !full;
  assign ctl.del = accept &&  is_del && !empty;

  // Chain of cells: cell 0 is the head, the new entry enters at its sorted
  // place, and deletes shift everything one step towards the head.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_entry;
    logic   left_ge;
    entry_t right_entry;

    assign cell_valid[i] = (count_q > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_ge    = cell_ge[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .valid_i       (cell_valid[i]),
      .new_entry_i   (new_entry),
      .left_entry_i  (left_entry),
      .left_ge_i     (left_ge),
      .right_entry_i (right_entry),
      .entry_o       (cell_entry[i]),
      .ge_o          (cell_ge[i])
    );
  end

  // Work out the result beat and the next count.
  always_comb begin
    count_d       = count_q;
    prio_out_d    = '0;
    payload_out_d = '0;
    status_d      = ST_DONE;
    if (ctl.ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl.del) begin
      count_d       = count_q - CNT_W'(1);
      prio_out_d    = cell_entry[0].prio;
      payload_out_d = cell_entry[0].payload;
    end else if (accept && is_del) begin
      status_d = ST_EMPTY;
    end else if (accept) begin
      status_d = ST_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= accept;
    end
  end

  // Result payload: hold until the next accepted command.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prio_out_q    <= prio_out_d;
      payload_out_q <= payload_out_d;
      status_q      <= status_d;
    end
  end

  assign busy          = busy_q;
  assign done_o        = busy_q;
  assign prio_out_o    = prio_out_q;
  assign payload_out_o = payload_out_q;
  assign status_o      = status_q;
  assign occupancy_o   = OCC_W'(count_q);

endmodule

`default_nettype wire

FILE: bench/spq_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_checker: scoreboard for the stable priority queue
// Watches the command and result channels, keeps its own copy of the queue
// contents and compares each result strobe with the oldest predicted reply.
// ----------------------------------------------------------------------------

module spq_checker (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start,
  input  wire                         busy,
  input  wire                         cmd_i,
  input  wire  [spq_pkg::PRIO_W-1:0]  prio_i,
  input  wire  [spq_pkg::DATA_W-1:0]  payload_i,
  input  wire                         done_i,
  input  wire  [spq_pkg::PRIO_W-1:0]  rprio_i,
  input  wire  [spq_pkg::DATA_W-1:0]  rpayload_i,
  input  wire  [1:0]                  status_i,
  input  wire  [spq_pkg::OCC_W-1:0]   occupancy_i,
  output int                          fail_count_o,
  output int                          owed_o,
  output int                          served_o,
  output int                          full_drops_o,
  output int                          empty_hits_o
);

  import spq_pkg::*;

  typedef struct {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] payload;
    status_e           status;
    logic [OCC_W-1:0]  occ;
  } reply_t;

  entry_t held_entries[$];   // queue contents, oldest first
  reply_t owed_replies[$];   // replies still to come, oldest first

  int mismatches   = 0;
  int served       = 0;
  int full_drops   = 0;
  int empty_hits   = 0;
  int replies_seen = 0;

  assign fail_count_o = mismatches;
  assign owed_o       = owed_replies.size();
  assign served_o     = served;
  assign full_drops_o = full_drops;
  assign empty_hits_o = empty_hits;

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH reply %0d: %s", $time, replies_seen, msg);
    mismatches++;
  endtask

  // Apply one command to the held entries and work out the reply it owes.
  function automatic reply_t serve_command(input cmd_e c, input logic [PRIO_W-1:0] p,
                                           input logic [DATA_W-1:0] d);
    reply_t r;
    entry_t e;
    int     best;
    r.prio    = '0;
    r.payload = '0;
    r.status  = ST_DONE;
    if (c == CMD_INSERT) begin
      if (held_entries.size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        e.prio    = p;
        e.payload = d;
        held_entries.push_back(e);
      end
    end else if (held_entries.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // earliest entry with the strictly greatest priority
      best = 0;
      for (int i = 1; i < held_entries.size(); i++)
        if (held_entries[i].prio > held_entries[best].prio) best = i;
      r.prio    = held_entries[best].prio;
      r.payload = held_entries[best].payload;
      held_entries.delete(best);
    end
    r.occ = OCC_W'(held_entries.size());
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    if (!rst_ni) begin
      held_entries.delete();
      owed_replies.delete();
    end else begin
      // compare first: a strobe always belongs to an earlier command
      if (done_i) begin
        if (owed_replies.size() == 0) begin
          flag_mismatch("result strobe with no command outstanding");
        end else begin
          want = owed_replies.pop_front();
          if (rprio_i !== want.prio)
            flag_mismatch($sformatf("prio_out %0h, want %0h", rprio_i, want.prio));
          if (rpayload_i !== want.payload)
            flag_mismatch($sformatf("payload_out %0h, want %0h", rpayload_i, want.payload));
          if (status_i !== want.status)
            flag_mismatch($sformatf("status %0d, want %s", status_i, want.status.name()));
          if (occupancy_i !== want.occ)
            flag_mismatch($sformatf("occupancy %0d, want %0d", occupancy_i, want.occ));
          unique case (want.status)
            ST_FULL:  full_drops++;
            ST_EMPTY: empty_hits++;
            default:  served++;
          endcase
        end
        replies_seen++;
      end
      if (start && !busy)
        owed_replies.push_back(serve_command(cmd_e'(cmd_i), prio_i, payload_i));
    end
  end

endmodule

FILE: bench/stable_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: command-level test of the stable priority queue
// Drives insert and delete beats with random gaps, lets spq_checker predict
// and compare every result strobe, and gives the verdict at the end.
// ----------------------------------------------------------------------------

module stable_priority_queue_tb;

  import spq_pkg::*;

  localparam int STALL_LIMIT = 2000;  // idle cycles before the run is abandoned
  localparam int PHASE_BEATS = 450;   // random beats per idling phase

  // Hold every input at a known value from time zero.
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start        = 1'b0;
  logic                cmd_i        = CMD_INSERT;
  logic [PRIO_W-1:0]   prio_in_i    = '0;
  logic [DATA_W-1:0]   payload_in_i = '0;

  wire                 busy;
  wire                 done_o;
  wire  [PRIO_W-1:0]   prio_out_o;
  wire  [DATA_W-1:0]   payload_out_o;
  wire  [1:0]          status_o;
  wire  [OCC_W-1:0]    occupancy_o;

  int fail_count;
  int owed;
  int served;
  int full_drops;
  int empty_hits;
  int beats_sent = 0;
  int idle_run   = 0;

  stable_priority_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .prio_in_i     (prio_in_i),
    .payload_in_i  (payload_in_i),
    .done_o        (done_o),
    .prio_out_o    (prio_out_o),
    .payload_out_o (payload_out_o),
    .status_o      (status_o),
    .occupancy_o   (occupancy_o)
  );

  spq_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .prio_i       (prio_in_i),
    .payload_i    (payload_in_i),
    .done_i       (done_o),
    .rprio_i      (prio_out_o),
    .rpayload_i   (payload_out_o),
    .status_i     (status_o),
    .occupancy_i  (occupancy_o),
    .fail_count_o (fail_count),
    .owed_o       (owed),
    .served_o     (served),
    .full_drops_o (full_drops),
    .empty_hits_o (empty_hits)
  );

  // 20 ns clock.
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog: count cycles in which neither a command nor a result is taken.
  // The queue answers every accepted command with a registered result strobe,
  // so a long quiet stretch can only mean a hang.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      idle_run <= 0;
    end else if (idle_run + 1 >= STALL_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Issue one command beat. First idle with start low while each draw hits
  // the given chance in a hundred, then hold the beat until the edge at
  // which busy is low. The caller's next beat is driven in the same step as
  // this acceptance, so start is only ever assigned once per step.
  task automatic send_command(input cmd_e c, input logic [PRIO_W-1:0] p,
                              input logic [DATA_W-1:0] d, input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start        <= 1'b1;
    cmd_i        <= c;
    prio_in_i    <= p;
    payload_in_i <= d;
    do @(posedge clk_i); while (busy);
    beats_sent++;
  endtask

  // Favour a handful of low priorities so that ties, and hence the FIFO
  // order among equals, come up often; mix in the extremes and the full range.
  function automatic logic [PRIO_W-1:0] pick_prio();
    int r;
    r = $urandom_range(99);
    if (r < 45)      return PRIO_W'($urandom_range(3));
    else if (r < 55) return ($urandom_range(1) != 0) ? '1 : '0;
    else             return PRIO_W'($urandom_range(255));
  endfunction

  // Random traffic in bursts: filling bursts drive the queue to full and
  // past it, draining bursts empty it and beyond, balanced ones churn the
  // middle. Each burst keeps one bias so the extremes are actually reached.
  task automatic run_traffic(input int n_beats, input int gap_pct);
    int   sent;
    int   burst;
    int   ins_pct;
    cmd_e c;
    sent = 0;
    while (sent < n_beats) begin
      case ($urandom_range(2))
        0:       ins_pct = 80;
        1:       ins_pct = 20;
        default: ins_pct = 50;
      endcase
      burst = $urandom_range(30, 4);
      for (int i = 0; i < burst && sent < n_beats; i++) begin
        c = ($urandom_range(99) < ins_pct) ? CMD_INSERT : CMD_DELETE;
        send_command(c, pick_prio(), DATA_W'($urandom), gap_pct);
        sent++;
      end
    end
  endtask

  initial begin
    // Hold reset, then release it on a rising edge.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: delete on an empty queue, the priority and payload
    // extremes, a run of equal priorities that must leave in arrival order,
    // and a final delete that finds the queue empty again.
    send_command(CMD_DELETE, '0, '0, 0);
    send_command(CMD_INSERT, '1, '1, 0);
    send_command(CMD_INSERT, '0, '0, 0);
    send_command(CMD_INSERT, 8'd7, 32'h0000_00A1, 0);
    send_command(CMD_INSERT, 8'd7, 32'h0000_00A2, 0);
    send_command(CMD_INSERT, 8'd7, 32'h0000_00A3, 0);
    send_command(CMD_INSERT, 8'd200, 32'h5555_AAAA, 0);
    for (int i = 0; i < 6; i++) send_command(CMD_DELETE, '1, '1, 0);
    send_command(CMD_DELETE, '0, '0, 0);

    // Three idling phases: sparse gaps, heavy gaps, then back to back.
    run_traffic(PHASE_BEATS, 6);
    run_traffic(PHASE_BEATS, 60);
    run_traffic(PHASE_BEATS, 0);
    start <= 1'b0;

    // Drain: wait for every owed result, then a short settling pause.
    while (owed != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Ran %0d command beats across sparse, heavy and no-gap phases.", beats_sent);
    $display("Served %0d beats with status done, %0d full drops, %0d empty deletes.",
             served, full_drops, empty_hits);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
bench/spq_checker.sv
bench/stable_priority_queue_tb.sv
